// ----- sv/servo_radio_aux_command_controller_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SERVO_RADIO_AUX_COMMAND_CONTROLLER_ASSERT_SVH
`define SERVO_RADIO_AUX_COMMAND_CONTROLLER_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define SRAC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define SRAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/srac_pkg.sv -----
// ----------------------------------------------------------------------------
// srac_pkg
// Types, codes, constants and helper functions of the servo/radio controller.
// ----------------------------------------------------------------------------
package srac_pkg;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 80;
    localparam int APB_AW      = 5;

    localparam logic [7:0] FRAME_MARK = 8'hA5;
    localparam logic [3:0] LEN_LEGACY = 4'd1;
    localparam logic [3:0] LEN_FRAME  = 4'd4;

    // four-byte command codes
    localparam logic [7:0] CMD_NOP       = 8'd0;
    localparam logic [7:0] CMD_OPEN      = 8'd1;
    localparam logic [7:0] CMD_CLOSE     = 8'd2;
    localparam logic [7:0] CMD_ANGLE     = 8'd3;
    localparam logic [7:0] CMD_AT_MODE   = 8'd4;
    localparam logic [7:0] CMD_RADIO     = 8'd5;
    localparam logic [7:0] CMD_HEARTBEAT = 8'd6;
    localparam logic [7:0] CMD_LED_MODE  = 8'd7;
    localparam logic [7:0] CMD_CLEAR     = 8'd8;

    // one-byte legacy codes
    localparam logic [7:0] LEG_OPEN  = 8'd1;
    localparam logic [7:0] LEG_CLOSE = 8'd2;
    localparam logic [7:0] LEG_AT_ON = 8'd4;

    localparam logic [1:0] SERVO_OFF  = 2'd0;
    localparam logic [1:0] SERVO_TURN = 2'd1;
    localparam logic [1:0] SERVO_DONE = 2'd2;

    localparam logic [1:0] LED_OFF     = 2'd0;
    localparam logic [1:0] LED_ON      = 2'd1;
    localparam logic [1:0] LED_PATTERN = 2'd2;

    localparam logic [2:0] REG_STEP_MS   = 3'd0;
    localparam logic [2:0] REG_POWER_MS  = 3'd1;
    localparam logic [2:0] REG_AT_TO_MS  = 3'd2;
    localparam logic [2:0] REG_STALE_MS  = 3'd3;
    localparam logic [2:0] REG_OPEN_ANG  = 3'd4;
    localparam logic [2:0] REG_CLOSE_ANG = 3'd5;

    localparam logic [7:0]  RST_STEP_MS   = 8'd10;
    localparam logic [11:0] RST_POWER_MS  = 12'd2200;
    localparam logic [16:0] RST_AT_TO_MS  = 17'd60000;
    localparam logic [16:0] RST_STALE_MS  = 17'd60000;
    localparam logic [7:0]  RST_OPEN_ANG  = 8'd10;
    localparam logic [7:0]  RST_CLOSE_ANG = 8'd170;

    localparam logic [9:0]  MS_LAST      = 10'd999;
    localparam logic [15:0] HB_SEC_MAX   = 16'hFFFE;
    localparam logic [15:0] HB_NEVER     = 16'hFFFF;
    // heartbeat stale limit is at most 17 bits, so an 18-bit capped age suffices
    localparam logic [17:0] HB_MS_CAP    = 18'd131072;
    localparam logic [2:0]  LED_PH_LAST  = 3'd5;

    typedef struct packed {
        logic [3:0] pad;
        logic [7:0] frame_byte3;
        logic [7:0] frame_byte2;
        logic [7:0] frame_byte1;
        logic [7:0] frame_byte0;
        logic [3:0] frame_len;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  pad;
        logic [31:0] run_seconds;
        logic [7:0]  crc_error_count;
        logic [7:0]  command_count;
        logic [15:0] heartbeat_age_s;
        logic        led_level;
        logic        radio_at_mode;
        logic        radio_power_on;
        logic        servo_powered;
        logic [1:0]  servo_phase;
        logic [7:0]  servo_angle_out;
    } result_t;

    // CRC-8/SMBus over one byte, poly 0x07, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    localparam logic [7:0] CRC_AFTER_MARK = crc8_byte(8'h00, FRAME_MARK);

    function automatic logic [11:0] pattern_dur(input logic stale, input logic [2:0] ph);
        logic [11:0] d;
        d = 12'd0;
        if (stale) begin
            case (ph)
                3'd5:    d = 12'd600;
                default: d = 12'd100;
            endcase
        end else begin
            case (ph)
                3'd0:    d = 12'd400;
                3'd1:    d = 12'd200;
                3'd2:    d = 12'd100;
                3'd3:    d = 12'd200;
                3'd4:    d = 12'd100;
                default: d = 12'd3000;
            endcase
        end
        return d;
    endfunction

endpackage

// ----- sv/servo_radio_aux_command_controller.sv -----
// ----------------------------------------------------------------------------
// servo_radio_aux_command_controller
// Millisecond ticks and received frames drive servo slew, radio power and AT
// mode, heartbeat tracking, LED blinking and status counters.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                 | payload
//  s_axis    | in        | s_axis_tvalid/tready      | tdata: frame fields, tuser: action
//  m_axis    | out       | m_axis_tvalid/tready      | tdata: status fields
//  apb       | in        | psel/penable/pwrite/pready| six config registers at 4*i
//
//  One item per clock sustained while m_axis_tready holds high; each result passes
//  the input register, then the result register, set by the single state update step.
//  Reset puts every counter, flag and state or config register at its reset value at once;
//  there is no clearing pass; the item and result data registers are not reset.
//  A stalled result holds in the result register; one more item still
//  transfers into the input register before s_axis_tready drops.
// ----------------------------------------------------------------------------
`include "servo_radio_aux_command_controller_assert.svh"

module servo_radio_aux_command_controller (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [3:0] frame_len, [11:4] frame_byte0, [19:12] frame_byte1,
    // [27:20] frame_byte2, [35:28] frame_byte3, [39:36] zero
    input  logic [srac_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] action
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] servo_angle_out, [9:8] servo_phase, [10] servo_powered,
    // [11] radio_power_on, [12] radio_at_mode, [13] led_level,
    // [29:14] heartbeat_age_s, [37:30] command_count, [45:38] crc_error_count,
    // [77:46] run_seconds, [79:78] zero
    output logic [srac_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [srac_pkg::APB_AW-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import srac_pkg::*;

    // configuration
    logic [7:0]  step_ms_reg;
    logic [11:0] power_ms_reg;
    logic [16:0] at_to_ms_reg;
    logic [16:0] stale_ms_reg;
    logic [7:0]  open_ang_reg;
    logic [7:0]  close_ang_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    // handshake
    logic     in_vld_reg;
    in_item_t item_reg;
    logic     action_reg;
    logic     out_vld_reg;
    result_t  res_reg;
    result_t  res_next;
    logic     advance;

    // state
    logic [7:0]  angle_reg, angle_next;
    logic [7:0]  goal_reg, goal_next;
    logic [1:0]  mode_reg, mode_next;
    logic [11:0] pow_reg, pow_next;
    logic [7:0]  step_reg, step_next;
    logic        at_reg, at_next;
    logic [16:0] at_ms_reg, at_ms_next;
    logic        radio_reg, radio_next;
    logic        hb_seen_reg, hb_seen_next;
    logic [17:0] hb_ms_reg, hb_ms_next;
    logic [9:0]  hb_frac_reg, hb_frac_next;
    logic [15:0] hb_sec_reg, hb_sec_next;
    logic [7:0]  cmds_reg, cmds_next;
    logic [7:0]  crcf_reg, crcf_next;
    logic [1:0]  led_mode_reg, led_mode_next;
    logic [2:0]  led_ph_reg, led_ph_next;
    logic [11:0] led_ms_reg, led_ms_next;
    logic        led_lvl_reg, led_lvl_next;
    logic [9:0]  ms_reg, ms_next;
    logic [31:0] up_reg, up_next;

    // decode helpers
    logic        cmd_vld;
    logic [7:0]  cmd_code;
    logic [7:0]  cmd_arg;
    logic        crc_bad;
    logic [7:0]  crc_calc;
    logic [7:0]  req_raw;
    logic [7:0]  req_lo;
    logic [7:0]  req_ang;
    logic [11:0] pow_inc;
    logic [7:0]  step_inc;
    logic [16:0] at_inc;
    logic [11:0] led_inc;
    logic        stale;
    logic [2:0]  ph;
    logic [11:0] dur;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[APB_AW-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ms_reg   <= RST_STEP_MS;
            power_ms_reg  <= RST_POWER_MS;
            at_to_ms_reg  <= RST_AT_TO_MS;
            stale_ms_reg  <= RST_STALE_MS;
            open_ang_reg  <= RST_OPEN_ANG;
            close_ang_reg <= RST_CLOSE_ANG;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_STEP_MS:   step_ms_reg   <= pwdata[7:0];
                REG_POWER_MS:  power_ms_reg  <= pwdata[11:0];
                REG_AT_TO_MS:  at_to_ms_reg  <= pwdata[16:0];
                REG_STALE_MS:  stale_ms_reg  <= pwdata[16:0];
                REG_OPEN_ANG:  open_ang_reg  <= pwdata[7:0];
                REG_CLOSE_ANG: close_ang_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_STEP_MS:   prdata = {24'd0, step_ms_reg};
            REG_POWER_MS:  prdata = {20'd0, power_ms_reg};
            REG_AT_TO_MS:  prdata = {15'd0, at_to_ms_reg};
            REG_STALE_MS:  prdata = {15'd0, stale_ms_reg};
            REG_OPEN_ANG:  prdata = {24'd0, open_ang_reg};
            REG_CLOSE_ANG: prdata = {24'd0, close_ang_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // input register, result register
    assign advance       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_vld_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg   <= s_axis_tdata;
            action_reg <= s_axis_tuser;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // frame decode
    always_comb
    begin
        cmd_vld  = 1'b0;
        cmd_code = item_reg.frame_byte1;
        cmd_arg  = item_reg.frame_byte2;
        crc_bad  = 1'b0;
        crc_calc = crc8_byte(crc8_byte(CRC_AFTER_MARK, item_reg.frame_byte1),
                             item_reg.frame_byte2);
        if (action_reg)
        begin
            if (item_reg.frame_len == LEN_LEGACY)
            begin
                case (item_reg.frame_byte0)
                    LEG_OPEN:
                    begin
                        cmd_vld  = 1'b1;
                        cmd_code = CMD_OPEN;
                        cmd_arg  = 8'd0;
                    end
                    LEG_CLOSE:
                    begin
                        cmd_vld  = 1'b1;
                        cmd_code = CMD_CLOSE;
                        cmd_arg  = 8'd0;
                    end
                    LEG_AT_ON:
                    begin
                        cmd_vld  = 1'b1;
                        cmd_code = CMD_AT_MODE;
                        cmd_arg  = 8'd1;
                    end
                    default: ;
                endcase
            end
            else if (item_reg.frame_len == LEN_FRAME && item_reg.frame_byte0 == FRAME_MARK)
            begin
                if (crc_calc != item_reg.frame_byte3)
                begin
                    crc_bad = 1'b1;
                end
                else
                begin
                    cmd_vld = 1'b1;
                end
            end
        end

        // clamp up to the open limit, then down to the closed limit
        req_raw = (cmd_code == CMD_OPEN)  ? open_ang_reg :
                  (cmd_code == CMD_CLOSE) ? close_ang_reg : cmd_arg;
        req_lo  = (req_raw < open_ang_reg) ? open_ang_reg : req_raw;
        req_ang = (req_lo > close_ang_reg) ? close_ang_reg : req_lo;
    end

    // tick arithmetic
    assign pow_inc  = (pow_reg == '1)    ? pow_reg    : pow_reg + 12'd1;
    assign step_inc = (step_reg == '1)   ? step_reg   : step_reg + 8'd1;
    assign at_inc   = (at_ms_reg == '1)  ? at_ms_reg  : at_ms_reg + 17'd1;
    assign led_inc  = (led_ms_reg == '1) ? led_ms_reg : led_ms_reg + 12'd1;

    always_comb
    begin
        angle_next    = angle_reg;
        goal_next     = goal_reg;
        mode_next     = mode_reg;
        pow_next      = pow_reg;
        step_next     = step_reg;
        at_next       = at_reg;
        at_ms_next    = at_ms_reg;
        radio_next    = radio_reg;
        hb_seen_next  = hb_seen_reg;
        hb_ms_next    = hb_ms_reg;
        hb_frac_next  = hb_frac_reg;
        hb_sec_next   = hb_sec_reg;
        cmds_next     = cmds_reg;
        crcf_next     = crcf_reg;
        led_mode_next = led_mode_reg;
        led_ph_next   = led_ph_reg;
        led_ms_next   = led_ms_reg;
        led_lvl_next  = led_lvl_reg;
        ms_next       = ms_reg;
        up_next       = up_reg;
        stale         = 1'b0;
        ph            = 3'd0;
        dur           = 12'd0;

        if (!action_reg)
        begin
            pow_next    = pow_inc;
            step_next   = step_inc;
            at_ms_next  = at_inc;
            led_ms_next = led_inc;
            hb_ms_next  = (hb_ms_reg == HB_MS_CAP) ? hb_ms_reg : hb_ms_reg + 18'd1;
            if (hb_frac_reg == MS_LAST)
            begin
                hb_frac_next = 10'd0;
                hb_sec_next  = (hb_sec_reg == HB_SEC_MAX) ? hb_sec_reg : hb_sec_reg + 16'd1;
            end
            else
            begin
                hb_frac_next = hb_frac_reg + 10'd1;
            end
            if (ms_reg == MS_LAST)
            begin
                ms_next = 10'd0;
                up_next = up_reg + 32'd1;
            end
            else
            begin
                ms_next = ms_reg + 10'd1;
            end

            if (mode_reg == SERVO_TURN)
            begin
                if (pow_inc >= power_ms_reg)
                begin
                    mode_next = SERVO_DONE;
                end
                else if (step_inc >= step_ms_reg)
                begin
                    step_next = 8'd0;
                    if (angle_reg < goal_reg)
                    begin
                        angle_next = angle_reg + 8'd1;
                    end
                    else if (angle_reg > goal_reg)
                    begin
                        angle_next = angle_reg - 8'd1;
                    end
                    else
                    begin
                        mode_next = SERVO_DONE;
                    end
                end
            end
            else if (mode_reg == SERVO_DONE)
            begin
                mode_next = SERVO_OFF;
            end

            if (at_reg && at_inc > at_to_ms_reg)
            begin
                at_next = 1'b0;
            end

            case (led_mode_reg)
                LED_OFF: led_lvl_next = 1'b0;
                LED_ON:  led_lvl_next = 1'b1;
                default:
                begin
                    stale = hb_seen_reg && (hb_ms_next > {1'b0, stale_ms_reg});
                    ph    = (led_ph_reg > LED_PH_LAST) ? 3'd0 : led_ph_reg;
                    dur   = pattern_dur(stale, ph);
                    if (led_inc > dur)
                    begin
                        led_lvl_next = ph[0];
                        led_ms_next  = 12'd0;
                        led_ph_next  = (ph == LED_PH_LAST) ? 3'd0 : ph + 3'd1;
                    end
                end
            endcase
        end
        else
        begin
            if (crc_bad)
            begin
                crcf_next = crcf_reg + 8'd1;
            end
            if (cmd_vld)
            begin
                cmds_next = cmds_reg + 8'd1;
                case (cmd_code) inside
                    CMD_OPEN, CMD_CLOSE, CMD_ANGLE:
                    begin
                        goal_next = req_ang;
                        if (mode_reg == SERVO_OFF)
                        begin
                            pow_next  = 12'd0;
                            step_next = 8'd0;
                            mode_next = SERVO_TURN;
                        end
                    end
                    CMD_AT_MODE:
                    begin
                        at_next = (cmd_arg != 8'd0);
                        if (cmd_arg != 8'd0)
                        begin
                            at_ms_next = 17'd0;
                        end
                    end
                    CMD_RADIO:
                    begin
                        radio_next = (cmd_arg != 8'd0);
                    end
                    CMD_HEARTBEAT:
                    begin
                        hb_seen_next = 1'b1;
                        hb_ms_next   = 18'd0;
                        hb_frac_next = 10'd0;
                        hb_sec_next  = 16'd0;
                    end
                    CMD_LED_MODE:
                    begin
                        led_mode_next = (cmd_arg > 8'd2) ? LED_PATTERN : cmd_arg[1:0];
                    end
                    CMD_CLEAR:
                    begin
                        cmds_next = 8'd0;
                        crcf_next = 8'd0;
                    end
                    default: ;
                endcase
            end
        end

        res_next                 = '0;
        res_next.servo_angle_out = angle_next;
        res_next.servo_phase     = mode_next;
        res_next.servo_powered   = (mode_next == SERVO_TURN);
        res_next.radio_power_on  = radio_next;
        res_next.radio_at_mode   = at_next;
        res_next.led_level       = led_lvl_next;
        res_next.heartbeat_age_s = hb_seen_next ? hb_sec_next : HB_NEVER;
        res_next.command_count   = cmds_next;
        res_next.crc_error_count = crcf_next;
        res_next.run_seconds     = up_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg    <= RST_CLOSE_ANG;
            goal_reg     <= RST_CLOSE_ANG;
            mode_reg     <= SERVO_OFF;
            pow_reg      <= '0;
            step_reg     <= '0;
            at_reg       <= 1'b0;
            at_ms_reg    <= '0;
            radio_reg    <= 1'b1;
            hb_seen_reg  <= 1'b0;
            hb_ms_reg    <= '0;
            hb_frac_reg  <= '0;
            hb_sec_reg   <= '0;
            cmds_reg     <= '0;
            crcf_reg     <= '0;
            led_mode_reg <= LED_PATTERN;
            led_ph_reg   <= '0;
            led_ms_reg   <= '0;
            led_lvl_reg  <= 1'b0;
            ms_reg       <= '0;
            up_reg       <= '0;
        end
        else if (advance)
        begin
            angle_reg    <= angle_next;
            goal_reg     <= goal_next;
            mode_reg     <= mode_next;
            pow_reg      <= pow_next;
            step_reg     <= step_next;
            at_reg       <= at_next;
            at_ms_reg    <= at_ms_next;
            radio_reg    <= radio_next;
            hb_seen_reg  <= hb_seen_next;
            hb_ms_reg    <= hb_ms_next;
            hb_frac_reg  <= hb_frac_next;
            hb_sec_reg   <= hb_sec_next;
            cmds_reg     <= cmds_next;
            crcf_reg     <= crcf_next;
            led_mode_reg <= led_mode_next;
            led_ph_reg   <= led_ph_next;
            led_ms_reg   <= led_ms_next;
            led_lvl_reg  <= led_lvl_next;
            ms_reg       <= ms_next;
            up_reg       <= up_next;
        end
    end

    `SRAC_ASSERT_NEXT(a_advance_fills_result, advance, out_vld_reg, "result register not loaded")
    `SRAC_ASSERT_NEXT(a_state_holds, !advance, $stable(angle_reg) && $stable(up_reg), "state moved without an item")
    `SRAC_ASSERT_ALWAYS(a_ms_range, ms_reg <= MS_LAST && hb_frac_reg <= MS_LAST, "millisecond counter out of range")
    `SRAC_ASSERT_ALWAYS(a_hb_sec_sat, hb_sec_reg <= HB_SEC_MAX, "heartbeat seconds past saturation")

endmodule
